// ===== design/mmdr_pkg.sv =====
// Shared constants and types for the MIDI message decoder with RPN/NRPN tracking.
`timescale 1ns / 1ps

package mmdr_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int CH_AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  localparam int STATUS_W = 8;
  localparam int DATA_W = 7;
  localparam int COUNT_W = 2;
  localparam int KIND_W = 4;
  localparam int CHAN_W = 4;
  localparam int WIDE_W = 14;

  localparam logic [KIND_W-1:0] EV_START    = 4'd0;
  localparam logic [KIND_W-1:0] EV_STOP     = 4'd1;
  localparam logic [KIND_W-1:0] EV_CONTINUE = 4'd2;
  localparam logic [KIND_W-1:0] EV_NOTEOFF  = 4'd3;
  localparam logic [KIND_W-1:0] EV_NOTEON   = 4'd4;
  localparam logic [KIND_W-1:0] EV_POLYAT   = 4'd5;
  localparam logic [KIND_W-1:0] EV_CC       = 4'd6;
  localparam logic [KIND_W-1:0] EV_PROGRAM  = 4'd7;
  localparam logic [KIND_W-1:0] EV_CHANAT   = 4'd8;
  localparam logic [KIND_W-1:0] EV_BEND     = 4'd9;
  localparam logic [KIND_W-1:0] EV_RPN      = 4'd10;
  localparam logic [KIND_W-1:0] EV_NRPN     = 4'd11;

  localparam logic [STATUS_W-1:0] ST_START    = 8'hFA;
  localparam logic [STATUS_W-1:0] ST_CONTINUE = 8'hFB;
  localparam logic [STATUS_W-1:0] ST_STOP     = 8'hFC;

  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_POLY_AT  = 4'hA;
  localparam logic [3:0] NIB_CC       = 4'hB;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
  localparam logic [3:0] NIB_BEND     = 4'hE;

  localparam logic [DATA_W-1:0] CC_DATA_MSB    = 7'd6;
  localparam logic [DATA_W-1:0] CC_DATA_LSB    = 7'd38;
  localparam logic [DATA_W-1:0] CC_NRPN_LSB    = 7'd98;
  localparam logic [DATA_W-1:0] CC_NRPN_MSB    = 7'd99;
  localparam logic [DATA_W-1:0] CC_RPN_LSB     = 7'd100;
  localparam logic [DATA_W-1:0] CC_RPN_MSB     = 7'd101;
  localparam logic [DATA_W-1:0] CC_RESET_FIRST = 7'd120;
  localparam logic [DATA_W-1:0] CC_RESET_LAST  = 7'd123;

  localparam logic [COUNT_W-1:0] CNT_SHORT = 2'd2;
  localparam logic [COUNT_W-1:0] CNT_FULL  = 2'd3;

  typedef struct packed {
    logic              rpn_sel;
    logic [WIDE_W-1:0] rpn_par;
    logic              nrpn_sel;
    logic [WIDE_W-1:0] nrpn_par;
  } chst_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] chan;
    logic [DATA_W-1:0] v1;
    logic [DATA_W-1:0] v2;
    logic [WIDE_W-1:0] wide;
    logic              last;
  } res_t;

endpackage

// ===== design/mmdr_if.sv =====
// Handshake interfaces for the message input and event output channels.
`timescale 1ns / 1ps

interface mmdr_in_if;
  logic                           valid;
  logic                           ready;
  logic [mmdr_pkg::STATUS_W-1:0]  status_byte;
  logic [mmdr_pkg::DATA_W-1:0]    data_first;
  logic [mmdr_pkg::DATA_W-1:0]    data_second;
  logic [mmdr_pkg::COUNT_W-1:0]   byte_count;

  modport source (output valid, status_byte, data_first, data_second, byte_count,
                  input ready);
  modport sink (input valid, status_byte, data_first, data_second, byte_count,
                output ready);
endinterface

interface mmdr_out_if;
  logic                          valid;
  logic                          ready;
  logic [mmdr_pkg::KIND_W-1:0]   event_kind;
  logic [mmdr_pkg::CHAN_W-1:0]   channel_number;
  logic [mmdr_pkg::DATA_W-1:0]   first_value;
  logic [mmdr_pkg::DATA_W-1:0]   second_value;
  logic [mmdr_pkg::WIDE_W-1:0]   wide_value;
  logic                          last_of_run;

  modport source (output valid, event_kind, channel_number, first_value, second_value,
                  wide_value, last_of_run, input ready);
  modport sink (input valid, event_kind, channel_number, first_value, second_value,
                wide_value, last_of_run, output ready);
endinterface

// ===== design/midi_message_decoder_rpn_core.sv =====
// Top level: MIDI message decoder with per-channel RPN/NRPN tracking.
// Usage:
//   in_msg carries one complete message per word (status, two data bytes,
//   byte count). out_evt carries decoded event words, zero, one or two per
//   message, the final one flagged by last_of_run.
//   Per-channel parameter selection lives in a 16-entry memory, read when a
//   message is taken and written back when it leaves the decode stage; a bypass
//   register covers a message that reads the entry being written in the same cycle.
// The input word is registered in the decode stage, its events in the output buffer.
// Throughput: one message per cycle while out_evt.ready is high and each message
//   gives at most one event; a message giving two events fills the two-slot output
//   buffer, and the next waits until the single output port has drained a word.
// Reset: all selections clear immediately (per-entry valid flags); no
//   clearing pass. Output buffer and pipeline are emptied.
// Stall: while out_evt.ready is low the output buffer holds its words; the
//   decode stage stalls once the buffer cannot take its events, and
//   in_msg.ready drops in that same cycle.
`timescale 1ns / 1ps

module midi_message_decoder_rpn_core (
  input logic          clk,
  input logic          rst_n,
  mmdr_in_if.sink      in_msg,
  mmdr_out_if.source   out_evt
);

  // decode stage
  logic                            s1_v_r;
  logic [mmdr_pkg::STATUS_W-1:0]   s1_status_r;
  logic [mmdr_pkg::DATA_W-1:0]     s1_d1_r;
  logic [mmdr_pkg::DATA_W-1:0]     s1_d2_r;
  logic [mmdr_pkg::COUNT_W-1:0]    s1_cnt_r;

  // channel state memory
  mmdr_pkg::chst_t                 mem [mmdr_pkg::CHANNEL_COUNT];
  logic [mmdr_pkg::CHANNEL_COUNT-1:0] ent_valid_r;
  mmdr_pkg::chst_t                 rd_data_r;
  logic                            rd_valid_r;
  logic                            byp_sel_r;
  mmdr_pkg::chst_t                 byp_data_r;

  // output buffer
  mmdr_pkg::res_t                  ob0_r;
  mmdr_pkg::res_t                  ob1_r;
  logic [1:0]                      ob_cnt_r;

  logic                            in_fire;
  logic                            out_fire;
  logic                            s1_go;
  logic                            ob_free;
  logic [mmdr_pkg::CH_AW-1:0]      in_addr;
  logic [mmdr_pkg::CH_AW-1:0]      s1_addr;
  logic [mmdr_pkg::CHAN_W-1:0]     s1_ch;
  logic                            s1_tracked;
  mmdr_pkg::chst_t                 st_cur;
  mmdr_pkg::chst_t                 st_nxt;
  logic                            wr_en;
  logic [1:0]                      res_n;
  mmdr_pkg::res_t                  r0;
  mmdr_pkg::res_t                  r1;
  logic [mmdr_pkg::WIDE_W-1:0]     entry_wide;

  assign s1_ch      = s1_status_r[mmdr_pkg::CHAN_W-1:0];
  assign s1_addr    = s1_ch[mmdr_pkg::CH_AW-1:0];
  assign in_addr    = in_msg.status_byte[mmdr_pkg::CH_AW-1:0];
  assign s1_tracked = (int'(s1_ch) < mmdr_pkg::CHANNEL_COUNT);

  assign out_fire = out_evt.valid && out_evt.ready;
  assign ob_free  = (ob_cnt_r == 2'd0) || ((ob_cnt_r == 2'd1) && out_evt.ready);
  assign s1_go    = s1_v_r && ((res_n == 2'd0) || ob_free);
  assign in_msg.ready = !s1_v_r || s1_go;
  assign in_fire  = in_msg.valid && in_msg.ready;

  assign st_cur = byp_sel_r ? byp_data_r : (rd_valid_r ? rd_data_r : '0);

  always_comb begin
    res_n      = 2'd0;
    r0         = '0;
    r1         = '0;
    st_nxt     = st_cur;
    wr_en      = 1'b0;
    entry_wide = '0;
    r0.chan    = s1_ch;
    r1.chan    = s1_ch;
    if (s1_cnt_r == '0) begin
      res_n = 2'd0;
    end else if (s1_status_r == mmdr_pkg::ST_START) begin
      res_n   = 2'd1;
      r0.kind = mmdr_pkg::EV_START;
      r0.chan = '0;
    end else if (s1_status_r == mmdr_pkg::ST_STOP) begin
      res_n   = 2'd1;
      r0.kind = mmdr_pkg::EV_STOP;
      r0.chan = '0;
    end else if (s1_status_r == mmdr_pkg::ST_CONTINUE) begin
      res_n   = 2'd1;
      r0.kind = mmdr_pkg::EV_CONTINUE;
      r0.chan = '0;
    end else begin
      case (s1_status_r[7:4])
        mmdr_pkg::NIB_NOTE_OFF: begin
          if (s1_cnt_r == mmdr_pkg::CNT_FULL) begin
            res_n   = 2'd1;
            r0.kind = mmdr_pkg::EV_NOTEOFF;
            r0.v1   = s1_d1_r;
          end
        end
        mmdr_pkg::NIB_NOTE_ON: begin
          if (s1_cnt_r == mmdr_pkg::CNT_FULL) begin
            res_n = 2'd1;
            r0.v1 = s1_d1_r;
            if (s1_d2_r != '0) begin
              r0.kind = mmdr_pkg::EV_NOTEON;
              r0.v2   = s1_d2_r;
            end else begin
              r0.kind = mmdr_pkg::EV_NOTEOFF;
            end
          end
        end
        mmdr_pkg::NIB_POLY_AT: begin
          if (s1_cnt_r == mmdr_pkg::CNT_FULL) begin
            res_n   = 2'd1;
            r0.kind = mmdr_pkg::EV_POLYAT;
            r0.v1   = s1_d1_r;
            r0.v2   = s1_d2_r;
          end
        end
        mmdr_pkg::NIB_CC: begin
          if (s1_cnt_r == mmdr_pkg::CNT_FULL) begin
            res_n   = 2'd1;
            r0.kind = mmdr_pkg::EV_CC;
            r0.v1   = s1_d1_r;
            r0.v2   = s1_d2_r;
            wr_en   = s1_tracked;
            if (s1_tracked) begin
              case (s1_d1_r) inside
                mmdr_pkg::CC_DATA_MSB, mmdr_pkg::CC_DATA_LSB: begin
                  entry_wide = (s1_d1_r == mmdr_pkg::CC_DATA_MSB) ?
                               {s1_d2_r, 7'd0} : {7'd0, s1_d2_r};
                  r1.wide = entry_wide;
                  if (st_cur.rpn_sel) begin
                    res_n   = 2'd2;
                    r1.kind = mmdr_pkg::EV_RPN;
                    r1.v1   = st_cur.rpn_par[13:7];
                    r1.v2   = st_cur.rpn_par[6:0];
                  end else if (st_cur.nrpn_sel) begin
                    res_n   = 2'd2;
                    r1.kind = mmdr_pkg::EV_NRPN;
                    r1.v1   = st_cur.nrpn_par[13:7];
                    r1.v2   = st_cur.nrpn_par[6:0];
                  end
                end
                mmdr_pkg::CC_NRPN_LSB, mmdr_pkg::CC_NRPN_MSB: begin
                  if (!st_cur.nrpn_sel) begin
                    st_nxt.nrpn_par = '0;
                  end
                  st_nxt.nrpn_sel = 1'b1;
                  if (s1_d1_r == mmdr_pkg::CC_NRPN_LSB) begin
                    st_nxt.nrpn_par[6:0] = s1_d2_r;
                  end else begin
                    st_nxt.nrpn_par[13:7] = s1_d2_r;
                  end
                  st_nxt.rpn_sel = 1'b0;
                end
                mmdr_pkg::CC_RPN_LSB, mmdr_pkg::CC_RPN_MSB: begin
                  if (!st_cur.rpn_sel) begin
                    st_nxt.rpn_par = '0;
                  end
                  st_nxt.rpn_sel = 1'b1;
                  if (s1_d1_r == mmdr_pkg::CC_RPN_LSB) begin
                    st_nxt.rpn_par[6:0] = s1_d2_r;
                  end else begin
                    st_nxt.rpn_par[13:7] = s1_d2_r;
                  end
                  st_nxt.nrpn_sel = 1'b0;
                end
                [mmdr_pkg::CC_RESET_FIRST:mmdr_pkg::CC_RESET_LAST]: begin
                  st_nxt.rpn_sel  = 1'b0;
                  st_nxt.nrpn_sel = 1'b0;
                end
                default: begin
                  st_nxt = st_cur;
                end
              endcase
            end
          end
        end
        mmdr_pkg::NIB_PROGRAM: begin
          if (s1_cnt_r >= mmdr_pkg::CNT_SHORT) begin
            res_n   = 2'd1;
            r0.kind = mmdr_pkg::EV_PROGRAM;
            r0.v1   = s1_d1_r;
          end
        end
        mmdr_pkg::NIB_CHAN_AT: begin
          if (s1_cnt_r >= mmdr_pkg::CNT_SHORT) begin
            res_n   = 2'd1;
            r0.kind = mmdr_pkg::EV_CHANAT;
            r0.v1   = s1_d1_r;
          end
        end
        mmdr_pkg::NIB_BEND: begin
          if (s1_cnt_r == mmdr_pkg::CNT_FULL) begin
            res_n   = 2'd1;
            r0.kind = mmdr_pkg::EV_BEND;
            r0.wide = {s1_d2_r, s1_d1_r};
          end
        end
        default: begin
          res_n = 2'd0;
        end
      endcase
    end
    r0.last = (res_n == 2'd1);
    r1.last = 1'b1;
  end

  // decode stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= in_msg.status_byte;
      s1_d1_r     <= in_msg.data_first;
      s1_d2_r     <= in_msg.data_second;
      s1_cnt_r    <= in_msg.byte_count;
    end
  end

  // state memory: registered read on accept, write-back from decode stage
  always_ff @(posedge clk) begin
    if (s1_go && wr_en) begin
      mem[s1_addr] <= st_nxt;
    end
    if (in_fire) begin
      rd_data_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
      rd_valid_r  <= 1'b0;
      byp_sel_r   <= 1'b0;
    end else begin
      if (s1_go && wr_en) begin
        ent_valid_r[s1_addr] <= 1'b1;
      end
      if (in_fire) begin
        rd_valid_r <= ent_valid_r[in_addr];
        byp_sel_r  <= s1_go && wr_en && (s1_addr == in_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byp_data_r <= st_nxt;
    end
  end

  // output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_cnt_r <= 2'd0;
    end else if (s1_go && (res_n != 2'd0)) begin
      ob_cnt_r <= res_n;
    end else if (out_fire) begin
      ob_cnt_r <= ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (res_n != 2'd0)) begin
      ob0_r <= r0;
      ob1_r <= r1;
    end else if (out_fire) begin
      ob0_r <= ob1_r;
    end
  end

  assign out_evt.valid          = (ob_cnt_r != 2'd0);
  assign out_evt.event_kind     = ob0_r.kind;
  assign out_evt.channel_number = ob0_r.chan;
  assign out_evt.first_value    = ob0_r.v1;
  assign out_evt.second_value   = ob0_r.v2;
  assign out_evt.wide_value     = ob0_r.wide;
  assign out_evt.last_of_run    = ob0_r.last;

  a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= 2'd2)
    else $error("output buffer overfilled");

  a_ob_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (res_n != 2'd0) |=> out_evt.valid)
    else $error("decoded events not presented");

  a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_cnt_r == 2'd1) |-> ob0_r.last)
    else $error("final buffered word lacks last flag");

  a_byp_src: assert property (@(posedge clk) disable iff (!rst_n)
    byp_sel_r && $rose(s1_v_r) |-> $past(wr_en))
    else $error("bypass taken without a write-back");

endmodule
